FILE: hdl/nlpg_pkg.sv
// shared constants and types for the line point generator
package nlpg_pkg;

	localparam int MAX_SPAN  = 63;
	localparam int COORD_MAX = 2047;

	localparam int COORD_W = 11;
	localparam int DELTA_W = 7;
	localparam int POINT_W = 13;
	localparam int SPAN_W  = 6;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [POINT_W-1:0] point_t;
	typedef logic [SPAN_W-1:0]         span_t;

endpackage

FILE: hdl/naive_line_point_generator.sv
// line point generator: one segment in, its pixels out one word at a time
// first pixel: axis-aligned or zero segment, valid the cycle after accept;
//   sloped segment, valid after the 6-step divide plus fix-up
// throughput: one pixel per cycle while out_stall is low, up to 64 pixels a segment;
//   a new segment is taken the cycle after its last pixel leaves
// reset: arst_n clears the sequencer and out_valid at once; the block comes up idle
module naive_line_point_generator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  nlpg_pkg::coord_t        start_x,
	input  nlpg_pkg::coord_t        start_y,
	input  nlpg_pkg::delta_t        delta_x,
	input  nlpg_pkg::delta_t        delta_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output nlpg_pkg::point_t        point_x,
	output nlpg_pkg::point_t        point_y,
	output logic                    last_point
);
	import nlpg_pkg::*;

	// sequencer: idle, shared divide steps, floor fix-up, pixel emission
	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_FIX,
		S_EMIT
	} state_t;

	state_t                     state_q;

	// pixel position, held in the output register
	point_t                     px_q;
	point_t                     py_q;
	logic [SPAN_W:0]            left_q;     // pixels still to go after this one

	// per-pixel steps
	logic signed [1:0]          x_inc_q;    // -1, 0 or +1
	logic signed [DELTA_W-1:0]  y_inc_q;    // whole part of the slope, floored
	logic [DELTA_W-1:0]         frac_q;     // twice the slope remainder
	logic [7:0]                 den_q;      // twice the run length
	logic [7:0]                 acc_q;      // rounding accumulator

	// divider registers
	span_t                      a_q;        // run length |dx|
	logic                       dy_neg_q;
	span_t                      div_num_q;
	span_t                      div_rem_q;
	span_t                      div_quo_q;
	logic [2:0]                 div_cnt_q;

	// saturated input fields
	coord_t                     x0;
	coord_t                     y0;
	delta_t                     dx_c;
	delta_t                     dy_c;
	delta_t                     dx_abs;
	delta_t                     dy_abs;

	// shared compare and subtract
	logic [SPAN_W:0]            div_sh;
	logic                       div_ge;
	logic [SPAN_W:0]            div_diff;

	// next pixel
	logic [7:0]                 acc_sum;
	logic                       carry;
	logic                       in_acc;
	logic                       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		x0 = (start_x > coord_t'(COORD_MAX)) ? coord_t'(COORD_MAX) : start_x;
		y0 = (start_y > coord_t'(COORD_MAX)) ? coord_t'(COORD_MAX) : start_y;
		// pattern -64 saturates to -63
		dx_c = (delta_x < -delta_t'(MAX_SPAN)) ? -delta_t'(MAX_SPAN) : delta_x;
		dy_c = (delta_y < -delta_t'(MAX_SPAN)) ? -delta_t'(MAX_SPAN) : delta_y;
		dx_abs = dx_c[DELTA_W-1] ? -dx_c : dx_c;
		dy_abs = dy_c[DELTA_W-1] ? -dy_c : dy_c;
	end

	// one restoring step of |dy| / |dx|
	always_comb begin
		div_sh   = {div_rem_q, div_num_q[SPAN_W-1]};
		div_ge   = (div_sh >= {1'b0, a_q});
		div_diff = div_sh - {1'b0, a_q};
	end

	// rounding accumulator: carries once it reaches twice the run
	always_comb begin
		acc_sum = acc_q + {1'b0, frac_q};
		carry   = (acc_sum >= den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_valid  <= 1'b0;
			px_q       <= '0;
			py_q       <= '0;
			left_q     <= '0;
			x_inc_q    <= '0;
			y_inc_q    <= '0;
			frac_q     <= '0;
			den_q      <= '0;
			acc_q      <= '0;
			a_q        <= '0;
			dy_neg_q   <= 1'b0;
			div_num_q  <= '0;
			div_rem_q  <= '0;
			div_quo_q  <= '0;
			div_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						// first pixel is always the start point
						px_q     <= {2'b00, x0};
						py_q     <= {2'b00, y0};
						a_q      <= dx_abs[SPAN_W-1:0];
						dy_neg_q <= dy_c[DELTA_W-1];
						frac_q   <= '0;
						den_q    <= 8'd1;
						acc_q    <= '0;
						priority if (dx_c == '0) begin
							// vertical run, both ends
							x_inc_q   <= 2'sd0;
							y_inc_q   <= dy_c[DELTA_W-1] ? -delta_t'(1)
							            : delta_t'(1);
							left_q    <= dy_abs;
							state_q   <= S_EMIT;
							out_valid <= 1'b1;
						end else if (dy_c == '0) begin
							// horizontal run, both ends
							x_inc_q   <= dx_c[DELTA_W-1] ? -2'sd1 : 2'sd1;
							y_inc_q   <= '0;
							left_q    <= dx_abs;
							state_q   <= S_EMIT;
							out_valid <= 1'b1;
						end else begin
							// sloped, end point left out
							x_inc_q   <= dx_c[DELTA_W-1] ? -2'sd1 : 2'sd1;
							left_q    <= dx_abs - delta_t'(1);
							div_num_q <= dy_abs[SPAN_W-1:0];
							div_rem_q <= '0;
							div_quo_q <= '0;
							div_cnt_q <= 3'(SPAN_W - 1);
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					div_num_q <= {div_num_q[SPAN_W-2:0], 1'b0};
					div_rem_q <= div_ge ? div_diff[SPAN_W-1:0] : div_sh[SPAN_W-1:0];
					div_quo_q <= {div_quo_q[SPAN_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q - 3'd1;
					if (div_cnt_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					// turn the magnitude quotient into a floored one
					if (dy_neg_q && (div_rem_q != '0)) begin
						y_inc_q <= -({1'b0, div_quo_q} + delta_t'(1));
						frac_q  <= {a_q - div_rem_q, 1'b0};
					end else if (dy_neg_q) begin
						y_inc_q <= -{1'b0, div_quo_q};
						frac_q  <= '0;
					end else begin
						y_inc_q <= {1'b0, div_quo_q};
						frac_q  <= {div_rem_q, 1'b0};
					end
					// half of the denominator gives round half up
					acc_q     <= {2'b00, a_q};
					den_q     <= {1'b0, a_q, 1'b0};
					state_q   <= S_EMIT;
					out_valid <= 1'b1;
				end
				S_EMIT: begin
					if (out_acc) begin
						if (left_q == '0) begin
							out_valid <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							left_q <= left_q - 7'd1;
							px_q   <= px_q + {{(POINT_W-2){x_inc_q[1]}}, x_inc_q};
							py_q   <= py_q + {{(POINT_W-DELTA_W){y_inc_q[DELTA_W-1]}}, y_inc_q}
							          + {{(POINT_W-1){1'b0}}, carry};
							acc_q  <= carry ? (acc_sum - den_q) : acc_sum;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign point_x    = px_q;
	assign point_y    = py_q;
	assign last_point = (left_q == '0);

endmodule

FILE: hdl/nlpg_checker.sv
// port-level checks for the line point generator, bound to the top level
module nlpg_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic out_valid,
	input  logic out_stall,
	input  logic last_point
);

	// a pending word is never dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// no new segment while pixels are being sent
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while emitting");

	// a taken segment closes the input
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input still open after a segment was taken");

	// the marked pixel ends the segment
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_point |=> !out_valid)
		else $error("output continues after last pixel");

endmodule

bind naive_line_point_generator nlpg_checker u_nlpg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.last_point (last_point)
);

FILE: verif/naive_line_point_generator_test.sv
// testbench for the line point generator: directed and random segments, pixels checked in order
`timescale 1ns / 1ps

module naive_line_point_generator_test;
	import nlpg_pkg::*;

	typedef struct packed {
		point_t x;
		point_t y;
		logic   last;
	} pixel_t;

	class line_scoreboard;
		pixel_t expected_pixels[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		// work out every pixel of an accepted segment and queue them
		function void note_segment(coord_t sx, coord_t sy, delta_t dx, delta_t dy);
			int x0, y0, ddx, ddy, dir, mag, cnt, num, den, q;
			pixel_t p;
			x0 = (int'(sx) > COORD_MAX) ? COORD_MAX : int'(sx);
			y0 = (int'(sy) > COORD_MAX) ? COORD_MAX : int'(sy);
			ddx = dx;
			ddy = dy;
			if (ddx > MAX_SPAN) ddx = MAX_SPAN;
			if (ddx < -MAX_SPAN) ddx = -MAX_SPAN;
			if (ddy > MAX_SPAN) ddy = MAX_SPAN;
			if (ddy < -MAX_SPAN) ddy = -MAX_SPAN;
			if (ddx == 0) begin
				dir = (ddy < 0) ? -1 : 1;
				cnt = ((ddy < 0) ? -ddy : ddy) + 1;
				for (int k = 0; k < cnt; k++) begin
					p.x = point_t'(x0);
					p.y = point_t'(y0 + dir * k);
					p.last = (k == cnt - 1);
					expected_pixels.push_back(p);
				end
			end else if (ddy == 0) begin
				dir = (ddx < 0) ? -1 : 1;
				cnt = ((ddx < 0) ? -ddx : ddx) + 1;
				for (int k = 0; k < cnt; k++) begin
					p.x = point_t'(x0 + dir * k);
					p.y = point_t'(y0);
					p.last = (k == cnt - 1);
					expected_pixels.push_back(p);
				end
			end else begin
				// sloped: end point left out, y rounded half up with floor division
				dir = (ddx < 0) ? -1 : 1;
				mag = (ddx < 0) ? -ddx : ddx;
				den = 2 * mag;
				for (int k = 0; k < mag; k++) begin
					num = 2 * ddy * k + mag;
					if (num >= 0) q = num / den;
					else q = -((-num + den - 1) / den);
					p.x = point_t'(x0 + dir * k);
					p.y = point_t'(y0 + q);
					p.last = (k == mag - 1);
					expected_pixels.push_back(p);
				end
			end
		endfunction

		function void check_pixel(point_t px, point_t py, logic lp);
			pixel_t e;
			if (expected_pixels.size() == 0) begin
				$error("pixel with none expected: x=%0d y=%0d last=%0b", px, py, lp);
				errors++;
				return;
			end
			e = expected_pixels.pop_front();
			if (px !== e.x) begin
				$error("point_x: expected %0d, got %0d", e.x, px);
				errors++;
			end
			if (py !== e.y) begin
				$error("point_y: expected %0d, got %0d", e.y, py);
				errors++;
			end
			if (lp !== e.last) begin
				$error("last_point: expected %0b, got %0b", e.last, lp);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_pixels.size();
		endfunction
	endclass

	// worst case is far below this: the block's own time plus every pixel held up
	// by a full stall burst, plus a sender gap, for under 300 segments
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_SEGMENTS = 260;
	// the final stretch of random segments runs with no idling on either side
	localparam int CALM_FROM = 220;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t start_x = '0;
	coord_t start_y = '0;
	delta_t delta_x = '0;
	delta_t delta_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	point_t point_x;
	point_t point_y;
	logic   last_point;

	line_scoreboard sb = new();
	bit calm = 1'b0;
	int cycles = 0;
	int stall_left = 0;

	naive_line_point_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

	always #10 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("naive_line_point_generator test failed");
			$finish;
		end
	end

	// pixel side: check each word taken, then decide the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel(point_x, point_y, last_point);
		if (stall_left > 0) begin
			// still inside a stall burst
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			// start a stall burst of random length
			stall_left = $urandom_range(1, 7) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// segment side: optional gap, then hold the word until it is taken
	task automatic send_segment(input coord_t sx, input coord_t sy,
			input delta_t dx, input delta_t dy);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x  <= sx;
		start_y  <= sy;
		delta_x  <= dx;
		delta_y  <= dy;
		@(posedge clk);
		// payload stays put while the block holds it off
		while (in_stall) @(posedge clk);
		sb.note_segment(sx, sy, dx, dy);
	endtask

	// random segment: mostly full-range sloped lines, with axis-aligned,
	// zero-length and short ones mixed in
	task automatic send_random();
		coord_t sx, sy;
		delta_t dx, dy;
		int shape;
		sx = coord_t'($urandom);
		sy = coord_t'($urandom);
		dx = delta_t'($urandom);
		dy = delta_t'($urandom);
		shape = $urandom_range(0, 19);
		unique case (shape)
			0: begin
				dx = '0;
				dy = '0;
			end
			1, 2: dx = '0;
			3, 4: dy = '0;
			5, 6: begin
				dx = delta_t'(int'($urandom_range(0, 14)) - 7);
				dy = delta_t'(int'($urandom_range(0, 14)) - 7);
			end
			7: begin
				// corners of the coordinate range
				sx = $urandom_range(0, 1) ? '1 : '0;
				sy = $urandom_range(0, 1) ? '1 : '0;
			end
			default: ;
		endcase
		send_segment(sx, sy, dx, dy);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero extent: the start alone, marked last
		send_segment(11'd100, 11'd200, delta_t'(0), delta_t'(0));
		// vertical runs, including a saturated extent
		send_segment(11'd0, 11'd0, delta_t'(0), delta_t'(63));
		send_segment(11'd0, 11'd0, delta_t'(0), delta_t'(-63));
		send_segment(11'd2047, 11'd2047, delta_t'(0), delta_t'(-64));
		send_segment(11'd2047, 11'd2047, delta_t'(0), delta_t'(1));
		// horizontal runs, including a saturated extent
		send_segment(11'd2047, 11'd5, delta_t'(63), delta_t'(0));
		send_segment(11'd0, 11'd2047, delta_t'(-63), delta_t'(0));
		send_segment(11'd0, 11'd0, delta_t'(-64), delta_t'(0));
		send_segment(11'd1024, 11'd1024, delta_t'(-1), delta_t'(0));
		// sloped at the extremes: steepest diagonals and saturated both ways
		send_segment(11'd2047, 11'd2047, delta_t'(63), delta_t'(63));
		send_segment(11'd0, 11'd0, delta_t'(-63), delta_t'(-63));
		send_segment(11'd0, 11'd2047, delta_t'(-64), delta_t'(-64));
		send_segment(11'd2047, 11'd0, delta_t'(-64), delta_t'(63));
		// single-point sloped segments
		send_segment(11'd10, 11'd10, delta_t'(1), delta_t'(1));
		send_segment(11'd10, 11'd10, delta_t'(-1), delta_t'(-1));
		// shallow lines: one step of y over the whole run
		send_segment(11'd300, 11'd400, delta_t'(63), delta_t'(1));
		send_segment(11'd300, 11'd400, delta_t'(-63), delta_t'(-1));
		// exact ties round up, and negative sums floor rather than truncate
		send_segment(11'd50, 11'd50, delta_t'(2), delta_t'(1));
		send_segment(11'd50, 11'd50, delta_t'(2), delta_t'(-1));
		send_segment(11'd50, 11'd50, delta_t'(3), delta_t'(-1));
		send_segment(11'd0, 11'd0, delta_t'(6), delta_t'(-9));
		send_segment(11'd1365, 11'd682, delta_t'(42), delta_t'(-21));

		for (int n = 0; n < RANDOM_SEGMENTS; n++) begin
			if (n == CALM_FROM)
				calm = 1'b1;
			send_random();
		end
		in_valid <= 1'b0;

		// drain the remaining pixels, then a few spare cycles for strays
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("naive_line_point_generator test passed");
		else
			$display("naive_line_point_generator test failed");
		$finish;
	end

endmodule
